// ----- design/lcprf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LCP repeat finder package
// Shared item and result types, register indexes and queue depths.
// ----------------------------------------------------------------------------
package lcprf_pkg;

   localparam int LCP_W  = 16;
   localparam int CHAR_W = 7;
   localparam int POS_W  = 16;
   localparam int OCC_W  = 17;
   localparam int CHAR_COUNT = 128;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_LENGTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_KIND = 2'd1;

   localparam int ITEM_QUEUE_DEPTH   = 2;
   localparam int RESULT_QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [LCP_W-1:0]  lcp_value;
      logic [CHAR_W-1:0] bwt_char;
      logic [POS_W-1:0]  suffix_pos;
      logic              final_rank;
   } item_type;

   localparam int ITEM_W = $bits(item_type);

   typedef struct packed {
      logic [OCC_W-1:0] occurrences;
      logic [POS_W-1:0] repeat_pos;
      logic [LCP_W-1:0] repeat_len;
      logic             overflow;
      logic             last_of_run;
   } result_type;

   localparam int RESULT_W = $bits(result_type);

   typedef struct packed {
      logic [LCP_W-1:0] min_length;
      logic             repeat_kind;
   } cfg_type;

endpackage
`default_nettype wire

// ----- design/lcp_bwt_repeat_finder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LCP and BWT repeat finder
// Reports maximal or supermaximal repeats from a streamed suffix array.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// req_      in         req_push / req_full  lcp_value, bwt_char, suffix_pos,
//                                           final_rank
// rsp_      out        rsp_pop / rsp_empty  occurrences, repeat_pos,
//                                           repeat_len, overflow, last_of_run
// csr_      in         csr_valid/csr_ready  csr_index, csr_data
//
// A rank that closes nothing passes through the start, evaluate and done states
// of the back end. Each closed interval adds a scan over the BWT characters of
// the interval, the stack pop and the next evaluation, and the position read
// when it is reported. A rank that leaves a report pending passes it on before
// the next rank is taken. A final rank runs a second closing pass.
// Reset is synchronous and clears the queues, stack count and run state.
// The back end holds when the result queue is full; ranks wait in the
// two-entry rank queue, and csr_ready is always high.
// ----------------------------------------------------------------------------
module lcp_bwt_repeat_finder import lcprf_pkg::*; #(
   parameter int MAX_RANKS   = 65536,
   parameter int STACK_DEPTH = 16,
   parameter int ALPHABET    = 128
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_push,
   output logic                        req_full,
   input  wire logic [LCP_W-1:0]       req_lcp_value,
   input  wire logic [CHAR_W-1:0]      req_bwt_char,
   input  wire logic [POS_W-1:0]       req_suffix_pos,
   input  wire logic                   req_final_rank,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output logic [OCC_W-1:0]            rsp_occurrences,
   output logic [POS_W-1:0]            rsp_repeat_pos,
   output logic [LCP_W-1:0]            rsp_repeat_len,
   output logic                        rsp_overflow,
   output logic                        rsp_last_of_run,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int QW = 1 + $clog2(MAX_RANKS) + 1 + ITEM_W;

   cfg_type    cfg_ff, cfg_in;
   item_type   req_item;
   logic       q_push, q_full, q_pop, q_empty;
   logic [QW-1:0] q_in_data, q_out_data;
   logic       res_push, res_full;
   result_type res_in_data, res_out_data;

   assign csr_ready = 1'b1;
   assign req_item  = '{lcp_value: req_lcp_value, bwt_char: req_bwt_char,
                        suffix_pos: req_suffix_pos, final_rank: req_final_rank};

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_MIN_LENGTH) begin
            cfg_in.min_length = csr_data;
         end else if (csr_index == CSR_REPEAT_KIND) begin
            cfg_in.repeat_kind = csr_data[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{min_length: LCP_W'(1), repeat_kind: 1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lcprf_front #(.MAX_RANKS(MAX_RANKS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_item (req_item),
      .q_push   (q_push),
      .q_data   (q_in_data),
      .q_full   (q_full)
   );

   lcprf_fifo #(.WIDTH(QW), .DEPTH(ITEM_QUEUE_DEPTH)) u_rank_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_in_data),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (q_out_data),
      .empty (q_empty)
   );

   lcprf_back #(
      .MAX_RANKS   (MAX_RANKS),
      .STACK_DEPTH (STACK_DEPTH),
      .ALPHABET    (ALPHABET)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .q_data   (q_out_data),
      .res_full (res_full),
      .res_push (res_push),
      .res_data (res_in_data)
   );

   lcprf_fifo #(.WIDTH(RESULT_W), .DEPTH(RESULT_QUEUE_DEPTH)) u_result_queue (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .din   (res_in_data),
      .full  (res_full),
      .pop   (rsp_pop),
      .dout  (res_out_data),
      .empty (rsp_empty)
   );

   assign rsp_occurrences = res_out_data.occurrences;
   assign rsp_repeat_pos  = res_out_data.repeat_pos;
   assign rsp_repeat_len  = res_out_data.repeat_len;
   assign rsp_overflow    = res_out_data.overflow;
   assign rsp_last_of_run = res_out_data.last_of_run;

endmodule
`default_nettype wire

// ----- design/lcprf_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lcprf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule
`default_nettype wire

// ----- design/lcprf_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Small register FIFO
// Decouples producer and consumer; push and pop may coincide.
// ----------------------------------------------------------------------------
module lcprf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] din,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] dout,
   output logic                  empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = data_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ff] <= din;
      end
   end

endmodule
`default_nettype wire

// ----- design/lcprf_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Repeat finder front end
// Accepts ranks, assigns each its rank index and marks the first of a run.
// ----------------------------------------------------------------------------
module lcprf_front import lcprf_pkg::*; #(
   parameter int MAX_RANKS = 65536
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire item_type    req_item,
   output logic             q_push,
   output logic [1+$clog2(MAX_RANKS)+1+ITEM_W-1:0] q_data,
   input  wire logic        q_full
);

   localparam int RW = $clog2(MAX_RANKS) + 1;

   logic [RW-1:0] rank_ff, rank_in, idx;
   logic          accept;

   assign accept   = req_push && !q_full;
   assign req_full = q_full;
   assign q_push   = accept;
   assign idx      = (rank_ff >= RW'(MAX_RANKS)) ? '0 : rank_ff;
   assign q_data   = {rank_ff == '0, idx, req_item};

   always_comb begin
      rank_in = rank_ff;
      if (accept) begin
         rank_in = req_item.final_rank ? '0 : idx + RW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff <= '0;
      end else begin
         rank_ff <= rank_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/lcprf_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Repeat finder back end
// Interval stack, character and position stores, interval scan and report.
// ----------------------------------------------------------------------------
module lcprf_back import lcprf_pkg::*; #(
   parameter int MAX_RANKS   = 65536,
   parameter int STACK_DEPTH = 16,
   parameter int ALPHABET    = 128
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       q_empty,
   output logic            q_pop,
   input  wire logic [1+$clog2(MAX_RANKS)+1+ITEM_W-1:0] q_data,
   input  wire logic       res_full,
   output logic            res_push,
   output result_type      res_data
);

   localparam int AW = $clog2(MAX_RANKS);
   localparam int RW = AW + 1;
   localparam int SW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int SEEN_W = $clog2(ALPHABET);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_START = 3'd1;
   localparam logic [2:0] ST_EVAL  = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_POS   = 3'd4;
   localparam logic [2:0] ST_POSW  = 3'd5;
   localparam logic [2:0] ST_CLOSE = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;
   localparam logic [2:0] ST_FLUSH = 3'b000;

   logic [2:0] state_ff, state_in;
   logic [2:0] flush_ff, flush_in;

   // Control state.
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [LCP_W-1:0] thr_ff, thr_in;
   logic             lost_ff, lost_in;
   logic [LCP_W-1:0] prev_ff, prev_in;
   logic             pend_ff, pend_in;
   logic             pres_valid_ff, pres_valid_in;

   // Payload state.
   item_type         item_ff, item_in;
   logic [RW-1:0]    idx_ff, idx_in;
   logic             first_ff, first_in;
   logic             closing_ff, closing_in;
   logic [LCP_W-1:0] lcp_ff, lcp_in;
   logic [LCP_W-1:0] cprev_ff, cprev_in;
   logic [RW-1:0]    top_start_ff, top_start_in;
   logic [LCP_W-1:0] top_lcp_ff, top_lcp_in;
   logic [RW-1:0]    top_child_ff, top_child_in;
   logic [RW-1:0]    k_ff, k_in;
   logic             sfirst_ff, sfirst_in;
   logic [SEEN_W-1:0] fchar_ff, fchar_in;
   logic [ALPHABET-1:0] seen_ff, seen_in;
   result_type       pres_ff, pres_in;

   // Interval stack entries, read only below the cached top.
   logic [RW-1:0]    stk_start [STACK_DEPTH];
   logic [LCP_W-1:0] stk_lcp   [STACK_DEPTH];
   logic [RW-1:0]    stk_child [STACK_DEPTH];
   logic             stk_we;
   logic [SW-1:0]    stk_widx, below_idx;

   logic [SEEN_W-1:0] mod_tab [CHAR_COUNT];
   logic [SEEN_W-1:0] cur_char;

   logic              store_we, bwt_re, pos_re;
   logic [AW-1:0]     bwt_raddr, pos_raddr;
   logic [CHAR_W-1:0] bwt_rdata;
   logic [POS_W-1:0]  pos_rdata;

   item_type          q_item;
   logic [RW-1:0]     q_idx;
   logic              q_first;
   logic [RW-1:0]     a0;
   logic              push_cond, close_cond, hit, dup;

   assign {q_first, q_idx, q_item} = q_data;

   for (genvar g = 0; g < CHAR_COUNT; g++) begin : g_mod
      assign mod_tab[g] = SEEN_W'(g % ALPHABET);
   end

   assign cur_char   = mod_tab[bwt_rdata];
   assign below_idx  = SW'(cnt_ff - CW'(2));
   assign a0         = (idx_ff == '0) ? '0 : idx_ff - RW'(1);
   assign push_cond  = (lcp_ff == thr_ff && cprev_ff < thr_ff) || lcp_ff > thr_ff;
   assign close_cond = (lcp_ff < thr_ff) && (cnt_ff > CW'(1));

   lcprf_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_RANKS)) u_bwt_store (
      .clock (clock),
      .we    (store_we),
      .waddr (idx_ff[AW-1:0]),
      .wdata (item_ff.bwt_char),
      .re    (bwt_re),
      .raddr (bwt_raddr),
      .rdata (bwt_rdata)
   );

   lcprf_ram #(.WIDTH(POS_W), .DEPTH(MAX_RANKS)) u_pos_store (
      .clock (clock),
      .we    (store_we),
      .waddr (idx_ff[AW-1:0]),
      .wdata (item_ff.suffix_pos),
      .re    (pos_re),
      .raddr (pos_raddr),
      .rdata (pos_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      flush_in      = flush_ff;
      cnt_in        = cnt_ff;
      thr_in        = thr_ff;
      lost_in       = lost_ff;
      prev_in       = prev_ff;
      pend_in       = pend_ff;
      pres_valid_in = pres_valid_ff;
      item_in       = item_ff;
      idx_in        = idx_ff;
      first_in      = first_ff;
      closing_in    = closing_ff;
      lcp_in        = lcp_ff;
      cprev_in      = cprev_ff;
      top_start_in  = top_start_ff;
      top_lcp_in    = top_lcp_ff;
      top_child_in  = top_child_ff;
      k_in          = k_ff;
      sfirst_in     = sfirst_ff;
      fchar_in      = fchar_ff;
      seen_in       = seen_ff;
      pres_in       = pres_ff;
      q_pop         = 1'b0;
      store_we      = 1'b0;
      bwt_re        = 1'b0;
      bwt_raddr     = k_ff[AW-1:0];
      pos_re        = 1'b0;
      pos_raddr     = top_child_ff[AW-1:0];
      res_push      = 1'b0;
      res_data      = pres_ff;
      stk_we        = 1'b0;
      stk_widx      = cnt_ff[SW-1:0];
      hit           = 1'b0;
      dup           = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (flush_ff == ST_FLUSH && pres_valid_ff) begin
               if (!res_full) begin
                  res_push             = 1'b1;
                  res_data.last_of_run = 1'b1;
                  pres_valid_in        = 1'b0;
               end
            end else if (!q_empty) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               idx_in   = q_idx;
               first_in = q_first;
               state_in = ST_START;
            end
         end
         ST_START: begin
            store_we   = 1'b1;
            lcp_in     = item_ff.lcp_value;
            cprev_in   = prev_ff;
            closing_in = 1'b0;
            if (first_ff) begin
               cnt_in       = CW'(1);
               lost_in      = 1'b0;
               thr_in       = cfg.min_length;
               top_start_in = '0;
               top_lcp_in   = cfg.min_length;
               top_child_in = '0;
               stk_we       = 1'b1;
               stk_widx     = '0;
            end
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = ST_DONE;
            if (!cfg.repeat_kind) begin
               if (push_cond) begin
                  if (cnt_ff < CW'(STACK_DEPTH)) begin
                     stk_we       = 1'b1;
                     top_start_in = a0;
                     top_lcp_in   = lcp_ff;
                     top_child_in = idx_ff;
                     cnt_in       = cnt_ff + CW'(1);
                     if (lcp_ff > thr_ff) begin
                        thr_in = lcp_ff;
                     end
                  end else begin
                     lost_in = 1'b1;
                  end
               end else if (close_cond) begin
                  state_in = ST_SCAN;
               end
            end else begin
               if (lcp_ff == thr_ff && cprev_ff < thr_ff) begin
                  if (cnt_ff < CW'(STACK_DEPTH)) begin
                     stk_we       = 1'b1;
                     top_start_in = a0;
                     top_lcp_in   = lcp_ff;
                     top_child_in = idx_ff;
                     cnt_in       = cnt_ff + CW'(1);
                  end else begin
                     lost_in = 1'b1;
                  end
               end else if (lcp_ff > thr_ff) begin
                  stk_we       = 1'b1;
                  top_start_in = a0;
                  top_lcp_in   = lcp_ff;
                  top_child_in = idx_ff;
                  thr_in       = lcp_ff;
                  if (cnt_ff > CW'(1)) begin
                     stk_widx = SW'(cnt_ff - CW'(1));
                  end else begin
                     cnt_in = cnt_ff + CW'(1);
                  end
               end else if (close_cond) begin
                  state_in = ST_SCAN;
               end
            end
            if (state_in == ST_SCAN) begin
               k_in      = top_start_ff;
               pend_in   = 1'b0;
               sfirst_in = 1'b1;
               seen_in   = '0;
            end
         end
         ST_SCAN: begin
            if (pend_ff) begin
               if (!cfg.repeat_kind) begin
                  if (sfirst_ff) begin
                     fchar_in  = cur_char;
                     sfirst_in = 1'b0;
                  end else if (cur_char != fchar_ff) begin
                     hit = 1'b1;
                  end
               end else if (seen_ff[cur_char]) begin
                  dup = 1'b1;
               end else begin
                  seen_in[cur_char] = 1'b1;
               end
            end
            if (hit) begin
               pend_in  = 1'b0;
               state_in = ST_POS;
            end else if (dup) begin
               pend_in  = 1'b0;
               state_in = ST_CLOSE;
            end else if (k_ff < idx_ff) begin
               bwt_re  = 1'b1;
               k_in    = k_ff + RW'(1);
               pend_in = 1'b1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               state_in = cfg.repeat_kind ? ST_POS : ST_CLOSE;
            end
         end
         ST_POS: begin
            pos_re = 1'b1;
            if (cfg.repeat_kind) begin
               pos_raddr = top_start_ff[AW-1:0];
            end
            state_in = ST_POSW;
         end
         ST_POSW: begin
            if (!(pres_valid_ff && res_full)) begin
               if (pres_valid_ff) begin
                  res_push = 1'b1;
               end
               pres_in.occurrences = OCC_W'(idx_ff - top_start_ff);
               pres_in.repeat_pos  = pos_rdata;
               pres_in.repeat_len  = thr_ff;
               pres_in.overflow    = lost_ff;
               pres_in.last_of_run = 1'b0;
               pres_valid_in       = 1'b1;
               state_in            = ST_CLOSE;
            end
         end
         ST_CLOSE: begin
            if (!cfg.repeat_kind && lcp_ff >= stk_lcp[below_idx]) begin
               stk_we       = 1'b1;
               stk_widx     = SW'(cnt_ff - CW'(1));
               top_lcp_in   = lcp_ff;
               top_child_in = idx_ff;
               thr_in       = lcp_ff;
            end else begin
               cnt_in       = cnt_ff - CW'(1);
               top_start_in = stk_start[below_idx];
               top_lcp_in   = stk_lcp[below_idx];
               top_child_in = stk_child[below_idx];
               thr_in       = stk_lcp[below_idx];
            end
            state_in = (!cfg.repeat_kind || closing_ff) ? ST_EVAL : ST_DONE;
         end
         ST_DONE: begin
            if (!closing_ff) begin
               prev_in = item_ff.lcp_value;
               if (item_ff.final_rank) begin
                  closing_in = 1'b1;
                  lcp_in     = '0;
                  cprev_in   = item_ff.lcp_value;
                  idx_in     = idx_ff + RW'(1);
                  state_in   = ST_EVAL;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               cnt_in   = '0;
               prev_in  = '0;
               thr_in   = cfg.min_length;
               lost_in  = 1'b0;
               state_in = ST_IDLE;
            end
            if (state_in == ST_IDLE) begin
               flush_in = ST_FLUSH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (state_ff == ST_IDLE && !(pres_valid_ff)) begin
         flush_in = ST_START;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         flush_ff      <= ST_START;
         cnt_ff        <= '0;
         thr_ff        <= cfg.min_length;
         lost_ff       <= 1'b0;
         prev_ff       <= '0;
         pend_ff       <= 1'b0;
         pres_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         flush_ff      <= flush_in;
         cnt_ff        <= cnt_in;
         thr_ff        <= thr_in;
         lost_ff       <= lost_in;
         prev_ff       <= prev_in;
         pend_ff       <= pend_in;
         pres_valid_ff <= pres_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      idx_ff       <= idx_in;
      first_ff     <= first_in;
      closing_ff   <= closing_in;
      lcp_ff       <= lcp_in;
      cprev_ff     <= cprev_in;
      top_start_ff <= top_start_in;
      top_lcp_ff   <= top_lcp_in;
      top_child_ff <= top_child_in;
      k_ff         <= k_in;
      sfirst_ff    <= sfirst_in;
      fchar_ff     <= fchar_in;
      seen_ff      <= seen_in;
      pres_ff      <= pres_in;
      if (stk_we) begin
         stk_start[stk_widx] <= top_start_in;
         stk_lcp[stk_widx]   <= top_lcp_in;
         stk_child[stk_widx] <= top_child_in;
      end
   end

   // A pop always leaves the bottom entry in place.
   a_close_depth: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLOSE) |-> (cnt_ff > CW'(1)))
      else $error("interval closed with only the bottom entry open");

   a_res_space: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("result transfer into a full queue");

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(STACK_DEPTH))
      else $error("interval stack count beyond depth");

   // No rank is taken while a report of the previous rank is still held.
   a_flush_first: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !pres_valid_ff)
      else $error("new rank taken with a report still pending");

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Repeat finder testbench
// Streams suffix-array ranks into the repeat finder in runs, in both repeat
// modes and at several minimum lengths, and checks every reported repeat
// against a cycle-free prediction of the interval stack.
// ----------------------------------------------------------------------------
module tb_top;
   import lcprf_pkg::*;

   localparam int STK_DEPTH = 16;
   localparam int RESULT_CAP = 16;
   localparam int IDLE_LIMIT = 50000;
   localparam int DRAIN_CYCLES = 1000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic [LCP_W-1:0] req_lcp_value = '0;
   logic [CHAR_W-1:0] req_bwt_char = '0;
   logic [POS_W-1:0] req_suffix_pos = '0;
   logic req_final_rank = 1'b0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [OCC_W-1:0] rsp_occurrences;
   logic [POS_W-1:0] rsp_repeat_pos;
   logic [LCP_W-1:0] rsp_repeat_len;
   logic rsp_overflow;
   logic rsp_last_of_run;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   lcp_bwt_repeat_finder DUT (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_lcp_value(req_lcp_value), .req_bwt_char(req_bwt_char),
      .req_suffix_pos(req_suffix_pos), .req_final_rank(req_final_rank),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_occurrences(rsp_occurrences), .rsp_repeat_pos(rsp_repeat_pos),
      .rsp_repeat_len(rsp_repeat_len), .rsp_overflow(rsp_overflow),
      .rsp_last_of_run(rsp_last_of_run),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   item_type pending_ranks[$];
   result_type expected_repeats[$];
   int error_count = 0;
   int rank_count = 0;
   int repeat_count = 0;
   int overflow_count = 0;
   int idle_cycles = 0;
   bit req_fired = 1'b0;
   bit rsp_fired = 1'b0;
   bit bursty = 1'b0;
   int send_gap = 0;
   int pop_gap = 0;

   // Predicted block state.
   int unsigned cfg_min_length = 1;
   bit cfg_super = 1'b0;
   int unsigned int_start[STK_DEPTH];
   int unsigned int_lcp[STK_DEPTH];
   int unsigned int_child[STK_DEPTH];
   int unsigned int_count = 0;
   logic [CHAR_W-1:0] char_mem[65536];
   logic [POS_W-1:0] pos_mem[65536];
   int unsigned rank_index = 0;
   int unsigned threshold = 1;
   int unsigned last_lcp = 0;
   bit push_lost = 1'b0;
   int step_results = 0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   function automatic void add_repeat(input int unsigned occ, input int unsigned pos,
                                      input int unsigned len);
      result_type r;
      if (step_results >= RESULT_CAP) return;
      r.occurrences = occ[OCC_W-1:0];
      r.repeat_pos = pos[POS_W-1:0];
      r.repeat_len = len[LCP_W-1:0];
      r.overflow = push_lost;
      r.last_of_run = 1'b0;
      expected_repeats.push_back(r);
      step_results++;
   endfunction

   function automatic bit open_interval(input int unsigned a, input int unsigned l,
                                        input int unsigned h);
      if (int_count >= STK_DEPTH) begin
         push_lost = 1'b1;
         return 1'b0;
      end
      int_start[int_count] = a;
      int_lcp[int_count] = l;
      int_child[int_count] = h;
      int_count++;
      return 1'b1;
   endfunction

   function automatic bit chars_vary(input int unsigned a, input int unsigned i);
      bit seen[128];
      for (int unsigned k = a; k < i; k++) begin
         if (!seen[char_mem[k]]) begin
            seen[char_mem[k]] = 1'b1;
            if (k > a) return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic bit chars_unique(input int unsigned a, input int unsigned i);
      bit seen[128];
      for (int unsigned k = a; k < i; k++) begin
         if (seen[char_mem[k]]) return 1'b0;
         seen[char_mem[k]] = 1'b1;
      end
      return 1'b1;
   endfunction

   function automatic void maximal_rank(input int unsigned i, input int unsigned lcp,
                                        input int unsigned prev);
      int unsigned thr, a, h;
      for (int it = 0; it <= STK_DEPTH; it++) begin
         thr = threshold;
         if ((lcp == thr && prev < thr) || lcp > thr) begin
            if (open_interval(i == 0 ? 0 : i - 1, lcp, i) && lcp > thr) threshold = lcp;
            return;
         end
         if (lcp < thr && int_count > 1) begin
            a = int_start[int_count-1];
            h = int_child[int_count-1];
            if (chars_vary(a, i)) add_repeat(i - a, pos_mem[h], thr);
            int_count--;
            if (lcp >= int_lcp[int_count-1]) begin
               void'(open_interval(a, lcp, i));
               threshold = lcp;
            end else begin
               threshold = int_lcp[int_count-1];
            end
         end else begin
            return;
         end
      end
   endfunction

   function automatic bit super_rank(input int unsigned i, input int unsigned lcp,
                                     input int unsigned prev);
      int unsigned thr, a, a0;
      thr = threshold;
      a0 = i == 0 ? 0 : i - 1;
      if (lcp == thr && prev < thr) begin
         void'(open_interval(a0, lcp, i));
      end else if (lcp > thr) begin
         if (int_count > 1) int_count--;
         if (open_interval(a0, lcp, i)) threshold = lcp;
      end else if (lcp < thr && int_count > 1) begin
         a = int_start[int_count-1];
         if (chars_unique(a, i)) add_repeat(i - a, pos_mem[a], thr);
         int_count--;
         threshold = int_lcp[int_count-1];
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void predict_rank(input item_type it);
      int unsigned i, prev, lcp;
      step_results = 0;
      if (int_count == 0) begin
         push_lost = 1'b0;
         void'(open_interval(0, cfg_min_length, 0));
         threshold = cfg_min_length;
         rank_index = 0;
         last_lcp = 0;
      end
      i = rank_index;
      lcp = it.lcp_value;
      char_mem[i] = it.bwt_char;
      pos_mem[i] = it.suffix_pos;
      prev = last_lcp;
      if (cfg_super) void'(super_rank(i, lcp, prev));
      else maximal_rank(i, lcp, prev);
      last_lcp = lcp;
      rank_index = i + 1;
      if (it.final_rank) begin
         if (cfg_super) begin
            for (int k = 0; k < STK_DEPTH; k++)
               if (!super_rank(rank_index, 0, lcp)) break;
         end else begin
            maximal_rank(rank_index, 0, lcp);
         end
         int_count = 0;
         rank_index = 0;
         last_lcp = 0;
         threshold = cfg_min_length;
         push_lost = 1'b0;
      end
      if (step_results > 0) expected_repeats[$].last_of_run = 1'b1;
   endfunction

   // Rank and repeat transfers, checks and the watchdog.
   always @(posedge clock) begin
      req_fired = req_push && !req_full && !reset;
      rsp_fired = rsp_pop && !rsp_empty && !reset;
      if (req_fired) begin
         predict_rank({req_lcp_value, req_bwt_char, req_suffix_pos, req_final_rank});
         rank_count++;
      end
      if (rsp_fired) begin
         repeat_count++;
         if (rsp_overflow) overflow_count++;
         if (expected_repeats.size() == 0) begin
            report("unexpected repeat, occurrences", rsp_occurrences, 0);
         end else begin
            result_type e;
            e = expected_repeats.pop_front();
            if (rsp_occurrences !== e.occurrences)
               report("occurrences", rsp_occurrences, e.occurrences);
            if (rsp_repeat_pos !== e.repeat_pos)
               report("repeat_pos", rsp_repeat_pos, e.repeat_pos);
            if (rsp_repeat_len !== e.repeat_len)
               report("repeat_len", rsp_repeat_len, e.repeat_len);
            if (rsp_overflow !== e.overflow)
               report("overflow", rsp_overflow, e.overflow);
            if (rsp_last_of_run !== e.last_of_run)
               report("last_of_run", rsp_last_of_run, e.last_of_run);
         end
      end
      if (req_fired || rsp_fired || (csr_valid && csr_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog expired with %0d repeats outstanding.", expected_repeats.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Rank driver.
   always @(negedge clock) begin
      if (!reset && !(req_push && !req_fired)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_push <= 1'b0;
         end else if (pending_ranks.size() > 0) begin
            item_type it;
            it = pending_ranks.pop_front();
            req_lcp_value <= it.lcp_value;
            req_bwt_char <= it.bwt_char;
            req_suffix_pos <= it.suffix_pos;
            req_final_rank <= it.final_rank;
            req_push <= 1'b1;
            if ($urandom_range(0, 15) == 0) bursty = ~bursty;
            send_gap = bursty ? 0 : $urandom_range(0, 12);
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // Repeat consumer with random stalls.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_fired) pop_gap = bursty ? 0 : $urandom_range(0, 12);
         if (pop_gap > 0) begin
            pop_gap--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   function automatic void add_rank(input int unsigned lcp, input int unsigned ch,
                                    input int unsigned pos, input bit fin);
      item_type it;
      it.lcp_value = lcp[LCP_W-1:0];
      it.bwt_char = ch[CHAR_W-1:0];
      it.suffix_pos = pos[POS_W-1:0];
      it.final_rank = fin;
      pending_ranks.push_back(it);
   endfunction

   function automatic void add_random_run(input int unsigned len, input int unsigned m);
      int unsigned base, lcp, ch;
      base = $urandom_range(0, 125);
      for (int unsigned k = 0; k < len; k++) begin
         case ($urandom_range(0, 9))
            0: lcp = 0;
            1: lcp = $urandom_range(0, 65535);
            default: begin
               lcp = m + $urandom_range(0, 5);
               lcp = (lcp > 65535) ? 65535 : lcp;
               lcp = (lcp > 0) ? lcp - 1 : 0;
            end
         endcase
         ch = ($urandom_range(0, 9) < 7) ? base + $urandom_range(0, 2) : $urandom_range(0, 127);
         add_rank(lcp, ch, $urandom_range(0, 65535), k == len - 1);
      end
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input int unsigned value);
      @(negedge clock);
      csr_index <= idx;
      csr_data <= value[CSR_DATA_W-1:0];
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_MIN_LENGTH) cfg_min_length = value[CSR_DATA_W-1:0];
      else if (idx == CSR_REPEAT_KIND) cfg_super = value[0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input int unsigned m, input bit super_mode);
      write_csr(CSR_MIN_LENGTH, m);
      write_csr(CSR_REPEAT_KIND, super_mode);
   endtask

   task automatic drain();
      while (pending_ranks.size() > 0 || req_push || expected_repeats.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int unsigned m, input bit super_mode, input int n_runs);
      configure(m, super_mode);
      for (int r = 0; r < n_runs; r++) add_random_run($urandom_range(1, 24), m);
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed runs at reset configuration: field extremes, a short run
      // and a nesting deep enough to lose a push to the full stack.
      configure(1, 1'b0);
      add_rank(0, 0, 0, 1'b0);
      add_rank(65535, 127, 65535, 1'b0);
      add_rank(2, 5, 1, 1'b0);
      add_rank(1, 6, 2, 1'b1);
      add_rank(3, 9, 3, 1'b1);
      for (int unsigned k = 0; k < 19; k++)
         add_rank(k, k * 5 + 1, $urandom_range(0, 65535), k == 18);
      drain();
      run_phase(1, 1'b0, 1);

      // Supermaximal at the same length, then the extremes of the length.
      configure(1, 1'b1);
      add_rank(0, 3, 10, 1'b0);
      add_rank(2, 4, 11, 1'b0);
      add_rank(3, 5, 12, 1'b0);
      add_rank(1, 4, 13, 1'b1);
      drain();
      run_phase(1, 1'b1, 1);
      run_phase(65535, 1'b0, 1);
      run_phase(65535, 1'b1, 1);
      run_phase(2, 1'b0, 1);
      run_phase(3, 1'b1, 2);
      run_phase(1, 1'b0, 1);

      $display("Covered %0d ranks and %0d repeats, %0d with overflow set,",
               rank_count, repeat_count, overflow_count);
      $display("over both repeat modes and minimum lengths from 1 to 65535.");
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

// ----- lcp_bwt_repeat_finder.f -----
design/lcprf_pkg.sv
design/lcprf_ram.sv
design/lcprf_fifo.sv
design/lcprf_front.sv
design/lcprf_back.sv
design/lcp_bwt_repeat_finder.sv
bench/tb_top.sv
